// ===== hdl/quaternion_attitude_integrate_top_assert.svh =====
// Assertion macros for the quaternion attitude integrator.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef QUATERNION_ATTITUDE_INTEGRATE_TOP_ASSERT_SVH
`define QUATERNION_ATTITUDE_INTEGRATE_TOP_ASSERT_SVH

// Same-cycle implication.
`define QAI_CHECK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define QAI_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/qai_pkg.sv =====
// Shared types and constants of the quaternion attitude integrator.
// No dependencies; used by qai_isqrt, qai_div and the top level.
`default_nettype none
package qai_pkg;
	localparam logic [15:0] TIME_STEP_RESET = 16'd655;
	localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;
	localparam int FRONT_STAGES = 11;
	localparam int SQRT_STAGES = 16;
	localparam int DIV_STAGES = 9;
	localparam int MAG_W = 30;
	localparam int ROOT_W = 31;
	localparam int QUOT_W = 15;
	localparam int N2_W = 62;

	typedef struct packed {
		logic signed [15:0] orient_w;
		logic signed [15:0] orient_x;
		logic signed [15:0] orient_y;
		logic signed [15:0] orient_z;
		logic signed [15:0] omega_x;
		logic signed [15:0] omega_y;
		logic signed [15:0] omega_z;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} in_t;

	typedef struct packed {
		logic signed [15:0] new_w;
		logic signed [15:0] new_x;
		logic signed [15:0] new_y;
		logic signed [15:0] new_z;
		logic               zero_norm;
	} out_t;

	// Normalized magnitudes and signs riding alongside the root and quotient.
	typedef struct packed {
		logic [3:0][MAG_W-1:0] mag;
		logic [3:0]            neg;
		logic                  zero;
	} side_t;

	typedef struct packed {
		logic [3:0][QUOT_W-1:0] quot;
		logic [3:0]             neg;
		logic                   zero;
	} div_res_t;
endpackage
`default_nettype wire

// ===== hdl/qai_isqrt.sv =====
// Pipelined integer square root, two result bits per stage.
// Depends on qai_pkg for widths and the side-band type.
`default_nettype none
module qai_isqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [qai_pkg::N2_W-1:0]  in_n2,
	input  wire qai_pkg::side_t            in_side,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [qai_pkg::ROOT_W-1:0]     out_root,
	output qai_pkg::side_t                 out_side
);
	typedef struct packed {
		logic [61:0] n;
		logic [62:0] res;
	} sq_t;

	function automatic sq_t sq_step(input sq_t a, input int k);
		logic [62:0] bitv;
		logic [62:0] t;
		sq_t o;
		bitv = 63'd1 << (62 - 2 * k);
		t = a.res + bitv;
		if ({1'b0, a.n} >= t) begin
			o.n = a.n - t[61:0];
			o.res = (a.res >> 1) + bitv;
		end else begin
			o.n = a.n;
			o.res = a.res >> 1;
		end
		return o;
	endfunction

	logic [qai_pkg::SQRT_STAGES-1:0] vld_s;
	logic [qai_pkg::SQRT_STAGES:0]   go;
	sq_t                             st_s   [qai_pkg::SQRT_STAGES];
	qai_pkg::side_t                  side_s [qai_pkg::SQRT_STAGES];

	always_comb begin
		go[qai_pkg::SQRT_STAGES] = out_ready;
		for (int s = qai_pkg::SQRT_STAGES - 1; s >= 0; s--) begin
			go[s] = !vld_s[s] || go[s + 1];
		end
	end

	assign in_ready = go[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (go[0]) vld_s[0] <= in_valid;
			for (int s = 1; s < qai_pkg::SQRT_STAGES; s++) begin
				if (go[s]) vld_s[s] <= vld_s[s - 1];
			end
		end
	end

	for (genvar g = 0; g < qai_pkg::SQRT_STAGES; g++) begin : g_stage
		sq_t            src;
		qai_pkg::side_t src_side;
		if (g == 0) begin : g_first
			always_comb begin
				src.n = in_n2;
				src.res = '0;
				src_side = in_side;
			end
		end else begin : g_next
			always_comb begin
				src = st_s[g - 1];
				src_side = side_s[g - 1];
			end
		end
		always_ff @(posedge clk) begin
			if (go[g]) begin
				st_s[g] <= sq_step(sq_step(src, 2 * g), 2 * g + 1);
				side_s[g] <= src_side;
			end
		end
	end

	assign out_valid = vld_s[qai_pkg::SQRT_STAGES-1];
	assign out_root = st_s[qai_pkg::SQRT_STAGES-1].res[qai_pkg::ROOT_W-1:0];
	assign out_side = side_s[qai_pkg::SQRT_STAGES-1];
endmodule
`default_nettype wire

// ===== hdl/qai_div.sv =====
// Pipelined restoring divider, four lanes sharing one divisor (the root).
// Depends on qai_pkg for widths and the side-band and result types.
`default_nettype none
module qai_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [qai_pkg::ROOT_W-1:0] in_root,
	input  wire qai_pkg::side_t             in_side,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output qai_pkg::div_res_t               out_res
);
	typedef struct packed {
		logic [44:0] rem;
		logic [14:0] quo;
	} dv_t;

	function automatic dv_t dv_step(input dv_t a, input logic [30:0] r, input int i);
		logic [45:0] d;
		dv_t o;
		d = 46'(r) << i;
		o = a;
		if ({1'b0, a.rem} >= d) begin
			o.rem = a.rem - d[44:0];
			o.quo = a.quo | (15'd1 << i);
		end
		return o;
	endfunction

	logic [qai_pkg::DIV_STAGES-1:0] vld_s;
	logic [qai_pkg::DIV_STAGES:0]   go;
	dv_t                            dv_s   [qai_pkg::DIV_STAGES][4];
	logic [qai_pkg::ROOT_W-1:0]     r_s    [qai_pkg::DIV_STAGES];
	logic [3:0]                     neg_s  [qai_pkg::DIV_STAGES];
	logic                           zero_s [qai_pkg::DIV_STAGES];

	always_comb begin
		go[qai_pkg::DIV_STAGES] = out_ready;
		for (int s = qai_pkg::DIV_STAGES - 1; s >= 0; s--) begin
			go[s] = !vld_s[s] || go[s + 1];
		end
	end

	assign in_ready = go[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (go[0]) vld_s[0] <= in_valid;
			for (int s = 1; s < qai_pkg::DIV_STAGES; s++) begin
				if (go[s]) vld_s[s] <= vld_s[s - 1];
			end
		end
	end

	// Numerator: magnitude scaled to Q.14 plus half the divisor for rounding.
	always_ff @(posedge clk) begin
		if (go[0]) begin
			for (int k = 0; k < 4; k++) begin
				dv_s[0][k].rem <= {1'b0, in_side.mag[k], 14'b0} + 45'(in_root >> 1);
				dv_s[0][k].quo <= '0;
			end
			r_s[0] <= in_root;
			neg_s[0] <= in_side.neg;
			zero_s[0] <= in_side.zero;
		end
	end

	for (genvar g = 1; g < qai_pkg::DIV_STAGES; g++) begin : g_stage
		localparam int HI = qai_pkg::QUOT_W + 1 - 2 * g;
		always_ff @(posedge clk) begin
			if (go[g]) begin
				for (int k = 0; k < 4; k++) begin
					if (HI - 1 >= 0) begin
						dv_s[g][k] <= dv_step(dv_step(dv_s[g-1][k], r_s[g-1], HI),
							r_s[g-1], HI - 1);
					end else begin
						dv_s[g][k] <= dv_step(dv_s[g-1][k], r_s[g-1], HI);
					end
				end
				r_s[g] <= r_s[g - 1];
				neg_s[g] <= neg_s[g - 1];
				zero_s[g] <= zero_s[g - 1];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			out_res.quot[k] = dv_s[qai_pkg::DIV_STAGES-1][k].quo;
		end
		out_res.neg = neg_s[qai_pkg::DIV_STAGES-1];
		out_res.zero = zero_s[qai_pkg::DIV_STAGES-1];
	end

	assign out_valid = vld_s[qai_pkg::DIV_STAGES-1];
endmodule
`default_nettype wire

// ===== hdl/quaternion_attitude_integrate_top.sv =====
// Second-order quaternion attitude integrator, top level.
// Pipeline: 11 arithmetic stages, 16 square-root stages, 9 divider stages
// and 1 output register.
// Throughput: one item per cycle; each stage stalls only when the one after it is full.
// Reset (arst_n low): clears every valid bit and loads time_step with 655.
// Depends on qai_pkg, qai_isqrt, qai_div and the assertion header.
`default_nettype none
module quaternion_attitude_integrate_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_wen,
	input  wire logic [15:0]   cfg_wdata,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire qai_pkg::in_t  in_item,
	output logic               out_valid,
	input  wire logic          out_ready,
	output qai_pkg::out_t      out_item
);
	`include "quaternion_attitude_integrate_top_assert.svh"

	localparam int FS = qai_pkg::FRONT_STAGES;

	// Clamp to the symmetric signed 40-bit range.
	function automatic logic signed [39:0] sat40(input logic signed [63:0] x);
		if (x > 64'sd549755813887) return 40'sd549755813887;
		if (x < -64'sd549755813887) return -40'sd549755813887;
		return x[39:0];
	endfunction

	// ---------------------------------------------------------------
	// Time step register; the user must write it only while the pipeline is empty; the block does not enforce this.
	// ---------------------------------------------------------------
	logic [15:0] time_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= qai_pkg::TIME_STEP_RESET;
		end else if (cfg_wen) begin
			time_step_q <= cfg_wdata;
		end
	end

	// ---------------------------------------------------------------
	// Front pipeline flow control: a stage loads when it is empty or
	// when the stage after it loads, so bubbles collapse under a stall.
	// ---------------------------------------------------------------
	logic [FS:1]   vld_s;
	logic [FS+1:1] go;
	logic          sq_in_ready;

	always_comb begin
		go[FS+1] = sq_in_ready;
		for (int s = FS; s >= 1; s--) begin
			go[s] = !vld_s[s] || go[s + 1];
		end
	end

	assign in_ready = go[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (go[1]) vld_s[1] <= in_valid;
			for (int s = 2; s <= FS; s++) begin
				if (go[s]) vld_s[s] <= vld_s[s - 1];
			end
		end
	end

	// Unpack the item: index 0..3 = w,x,y,z for q; 0..2 = x,y,z for vectors.
	logic signed [15:0] qi  [4];
	logic signed [15:0] omi [3];
	logic signed [15:0] aci [3];
	logic signed [16:0] dt_ext;

	always_comb begin
		qi[0] = in_item.orient_w;
		qi[1] = in_item.orient_x;
		qi[2] = in_item.orient_y;
		qi[3] = in_item.orient_z;
		omi[0] = in_item.omega_x;
		omi[1] = in_item.omega_y;
		omi[2] = in_item.omega_z;
		aci[0] = in_item.accel_x;
		aci[1] = in_item.accel_y;
		aci[2] = in_item.accel_z;
		dt_ext = $signed({1'b0, time_step_q});
	end

	// Stage 1: v = w*dt (0.5*w*dt at 2^-27), a*q partial products, |w|^2 terms, dt^2.
	logic signed [15:0] q_s1   [4];
	logic signed [32:0] v_s1   [3];
	logic signed [31:0] aqp_s1 [3][4];
	logic [31:0]        wp_s1  [3];
	logic [31:0]        dsq_s1;

	always_ff @(posedge clk) begin
		if (go[1]) begin
			for (int j = 0; j < 4; j++) q_s1[j] <= qi[j];
			for (int i = 0; i < 3; i++) begin
				v_s1[i] <= omi[i] * dt_ext;
				wp_s1[i] <= $unsigned(32'(omi[i] * omi[i]));
				for (int j = 0; j < 4; j++) aqp_s1[i][j] <= aci[i] * qi[j];
			end
			dsq_s1 <= time_step_q * time_step_q;
		end
	end

	// Stage 2: v*q partial products; combine a*q; sum |w|^2; 0.5*dt^2 at 2^-26.
	logic signed [15:0] q_s2   [4];
	logic signed [48:0] vqp_s2 [3][4];
	logic signed [33:0] aq_s2  [4];
	logic [32:0]        wsq_s2;
	logic [24:0]        d26_s2;
	logic signed [33:0] aq_c   [4];

	always_comb begin
		aq_c[0] = -aqp_s1[0][1] - aqp_s1[1][2] - aqp_s1[2][3];
		aq_c[1] = aqp_s1[0][0] + aqp_s1[1][3] - aqp_s1[2][2];
		aq_c[2] = aqp_s1[1][0] + aqp_s1[2][1] - aqp_s1[0][3];
		aq_c[3] = aqp_s1[2][0] + aqp_s1[0][2] - aqp_s1[1][1];
	end

	always_ff @(posedge clk) begin
		if (go[2]) begin
			for (int j = 0; j < 4; j++) begin
				q_s2[j] <= q_s1[j];
				aq_s2[j] <= aq_c[j];
			end
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 4; j++) vqp_s2[i][j] <= v_s1[i] * q_s1[j];
			end
			wsq_s2 <= 33'(wp_s1[0]) + 33'(wp_s1[1]) + 33'(wp_s1[2]);
			d26_s2 <= 25'((33'(dsq_s1) + 33'd64) >> 7);
		end
	end

	// Stage 3: velocity term rounded to Q.28; |w|^2 * q.
	logic signed [15:0] q_s3  [4];
	logic signed [39:0] vt_s3 [4];
	logic signed [48:0] wq_s3 [4];
	logic signed [33:0] aq_s3 [4];
	logic [24:0]        d26_s3;
	logic signed [50:0] vq_c  [4];
	logic signed [50:0] vr_c  [4];

	always_comb begin
		vq_c[0] = -vqp_s2[0][1] - vqp_s2[1][2] - vqp_s2[2][3];
		vq_c[1] = vqp_s2[0][0] + vqp_s2[1][3] - vqp_s2[2][2];
		vq_c[2] = vqp_s2[1][0] + vqp_s2[2][1] - vqp_s2[0][3];
		vq_c[3] = vqp_s2[2][0] + vqp_s2[0][2] - vqp_s2[1][1];
		for (int k = 0; k < 4; k++) vr_c[k] = (vq_c[k] + 51'sd4096) >>> 13;
	end

	always_ff @(posedge clk) begin
		if (go[3]) begin
			for (int k = 0; k < 4; k++) begin
				q_s3[k] <= q_s2[k];
				vt_s3[k] <= sat40(64'(vr_c[k]));
				wq_s3[k] <= $signed(wsq_s2) * q_s2[k];
				aq_s3[k] <= aq_s2[k];
			end
			d26_s3 <= d26_s2;
		end
	end

	// Stage 4: acceleration bracket at 2^-36, rounded to 2^-24; q + velocity term.
	logic signed [37:0] b24_s4 [4];
	logic signed [39:0] qv_s4  [4];
	logic [24:0]        d26_s4;
	logic signed [49:0] b36_c  [4];
	logic signed [49:0] b24_c  [4];
	logic signed [40:0] qv_c   [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			b36_c[k] = aq_s3[k] * 50'sd2048 - wq_s3[k];
			b24_c[k] = (b36_c[k] + 50'sd2048) >>> 12;
			qv_c[k] = (41'(q_s3[k]) <<< 14) + 41'(vt_s3[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (go[4]) begin
			for (int k = 0; k < 4; k++) begin
				b24_s4[k] <= b24_c[k][37:0];
				qv_s4[k] <= sat40(64'(qv_c[k]));
			end
			d26_s4 <= d26_s3;
		end
	end

	// Stage 5: bracket times 0.5*dt^2, split into low and high partial products.
	logic [42:0]        lo_s5 [4];
	logic signed [45:0] hi_s5 [4];
	logic signed [39:0] qv_s5 [4];

	always_ff @(posedge clk) begin
		if (go[5]) begin
			for (int k = 0; k < 4; k++) begin
				lo_s5[k] <= b24_s4[k][17:0] * d26_s4;
				hi_s5[k] <= $signed(b24_s4[k][37:18]) * $signed({1'b0, d26_s4});
				qv_s5[k] <= qv_s4[k];
			end
		end
	end

	// Stage 6: join partial products, round by 22 bits to Q.28.
	logic signed [39:0] at_s6  [4];
	logic signed [39:0] qv_s6  [4];
	logic signed [63:0] prod_c [4];
	logic signed [63:0] atf_c  [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			prod_c[k] = (64'(hi_s5[k]) <<< 18) + $signed({21'b0, lo_s5[k]});
			atf_c[k] = (prod_c[k] + 64'sd2097152) >>> 22;
		end
	end

	always_ff @(posedge clk) begin
		if (go[6]) begin
			for (int k = 0; k < 4; k++) begin
				at_s6[k] <= sat40(atf_c[k]);
				qv_s6[k] <= qv_s5[k];
			end
		end
	end

	// Stage 7: final sum, split into magnitude and sign.
	logic [38:0]        mag_s7 [4];
	logic [3:0]         neg_s7;
	logic signed [39:0] sum_c  [4];

	always_comb begin
		for (int k = 0; k < 4; k++) sum_c[k] = sat40(64'(qv_s6[k]) + 64'(at_s6[k]));
	end

	always_ff @(posedge clk) begin
		if (go[7]) begin
			for (int k = 0; k < 4; k++) begin
				mag_s7[k] <= sum_c[k][39] ? 39'(-sum_c[k]) : sum_c[k][38:0];
				neg_s7[k] <= sum_c[k][39];
			end
		end
	end

	// Stage 8: leading-one position of the largest magnitude.
	logic [38:0] mag_s8 [4];
	logic [3:0]  neg_s8;
	logic [5:0]  pos_s8;
	logic        zero_s8;
	logic [38:0] or_c;
	logic [5:0]  pos_c;

	always_comb begin
		or_c = mag_s7[0] | mag_s7[1] | mag_s7[2] | mag_s7[3];
		pos_c = '0;
		for (int i = 0; i < 39; i++) begin
			if (or_c[i]) pos_c = 6'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (go[8]) begin
			for (int k = 0; k < 4; k++) mag_s8[k] <= mag_s7[k];
			neg_s8 <= neg_s7;
			pos_s8 <= pos_c;
			zero_s8 <= (or_c == '0);
		end
	end

	// Stage 9: shift all magnitudes so the largest lands in [2^29, 2^30).
	qai_pkg::side_t side_s9;
	logic [5:0]     shr_c;
	logic [5:0]     shl_c;

	always_comb begin
		shr_c = pos_s8 - 6'd29;
		shl_c = 6'd29 - pos_s8;
	end

	always_ff @(posedge clk) begin
		if (go[9]) begin
			for (int k = 0; k < 4; k++) begin
				if (pos_s8 >= 6'd29) begin
					side_s9.mag[k] <= 30'(mag_s8[k] >> shr_c);
				end else begin
					side_s9.mag[k] <= mag_s8[k][29:0] << shl_c;
				end
			end
			side_s9.neg <= neg_s8;
			side_s9.zero <= zero_s8;
		end
	end

	// Stage 10: squares. Stage 11: sum of squares.
	qai_pkg::side_t side_s10;
	logic [59:0]    sq_s10 [4];
	qai_pkg::side_t side_s11;
	logic [61:0]    n2_s11;

	always_ff @(posedge clk) begin
		if (go[10]) begin
			for (int k = 0; k < 4; k++) sq_s10[k] <= side_s9.mag[k] * side_s9.mag[k];
			side_s10 <= side_s9;
		end
		if (go[11]) begin
			n2_s11 <= 62'(sq_s10[0]) + 62'(sq_s10[1]) + 62'(sq_s10[2]) + 62'(sq_s10[3]);
			side_s11 <= side_s10;
		end
	end

	// ---------------------------------------------------------------
	// Root, then per-lane rounded divide of the magnitudes by the root.
	// ---------------------------------------------------------------
	logic                            sq_out_valid;
	logic                            dv_in_ready;
	logic [qai_pkg::ROOT_W-1:0]      sq_root;
	qai_pkg::side_t                  sq_side;
	logic                            dv_out_valid;
	logic                            go_out;
	qai_pkg::div_res_t               dv_res;

	qai_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s[FS]),
		.in_ready  (sq_in_ready),
		.in_n2     (n2_s11),
		.in_side   (side_s11),
		.out_valid (sq_out_valid),
		.out_ready (dv_in_ready),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	qai_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_out_valid),
		.in_ready  (dv_in_ready),
		.in_root   (sq_root),
		.in_side   (sq_side),
		.out_valid (dv_out_valid),
		.out_ready (go_out),
		.out_res   (dv_res)
	);

	// ---------------------------------------------------------------
	// Output register: apply signs, substitute identity for a zero sum.
	// Hold the result until the consumer takes the transfer.
	// ---------------------------------------------------------------
	logic          out_valid_q;
	qai_pkg::out_t out_item_q;
	qai_pkg::out_t res_c;
	logic [15:0]   lane_c [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			lane_c[k] = dv_res.neg[k] ? 16'(-{1'b0, dv_res.quot[k]}) : {1'b0, dv_res.quot[k]};
		end
		if (dv_res.zero) begin
			res_c.new_w = qai_pkg::UNIT_Q14;
			res_c.new_x = '0;
			res_c.new_y = '0;
			res_c.new_z = '0;
			res_c.zero_norm = 1'b1;
		end else begin
			res_c.new_w = $signed(lane_c[0]);
			res_c.new_x = $signed(lane_c[1]);
			res_c.new_y = $signed(lane_c[2]);
			res_c.new_z = $signed(lane_c[3]);
			res_c.zero_norm = 1'b0;
		end
	end

	assign go_out = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_out) begin
			out_valid_q <= dv_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (go_out) out_item_q <= res_c;
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	logic unit_range;

	always_comb begin
		unit_range = (out_item.new_w <= qai_pkg::UNIT_Q14) && (out_item.new_w >= -qai_pkg::UNIT_Q14)
			&& (out_item.new_x <= qai_pkg::UNIT_Q14) && (out_item.new_x >= -qai_pkg::UNIT_Q14)
			&& (out_item.new_y <= qai_pkg::UNIT_Q14) && (out_item.new_y >= -qai_pkg::UNIT_Q14)
			&& (out_item.new_z <= qai_pkg::UNIT_Q14) && (out_item.new_z >= -qai_pkg::UNIT_Q14);
	end

	`QAI_CHECK_NOW(a_zero_identity, out_valid && out_item.zero_norm, out_item.new_w == qai_pkg::UNIT_Q14 && out_item.new_x == '0 && out_item.new_y == '0 && out_item.new_z == '0, "zero sum without identity")
	`QAI_CHECK_NOW(a_unit_range, out_valid, unit_range, "normalized component out of range")
	`QAI_CHECK_NEXT(a_take_enters, in_valid && in_ready, vld_s[1], "transfer did not enter stage 1")
	`QAI_CHECK_NEXT(a_front_hold, vld_s[FS] && !sq_in_ready, vld_s[FS] && $stable(n2_s11), "stalled front stage lost its item")
endmodule
`default_nettype wire
